/* rtl/central_difference_gradient_unit_macros.svh */
// ----------------------------------------------------------------------------
// central difference gradient unit assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CDG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/cdg_pkg.sv */
// ----------------------------------------------------------------------------
// cdg_pkg
// sizes, command and status types of the central difference gradient unit
// ----------------------------------------------------------------------------
package cdg_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W     = 8;
	localparam int GRAD_W    = 8;
	localparam int MAG_W     = 8;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = $clog2(MAX_HEIGHT);
	localparam int SQ_W      = 2 * GRAD_W;
	localparam int STEP_W    = $clog2(MAG_W);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

	// line store access of one step of the sequencer
	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_READ_CUR,
		MEM_READ_LEFT,
		MEM_READ_RIGHT,
		MEM_WRITE_CUR
	} mem_phase_t;

	// which of the up to three results of a pixel is being built
	typedef enum logic [1:0] {
		KIND_UPPER,
		KIND_LEFT,
		KIND_CORNER
	} res_kind_t;

	typedef struct packed {
		logic       capture;
		mem_phase_t mem_phase;
		logic       load_res;
		res_kind_t  kind;
		logic       push_out;
		logic       advance;
	} ctrl_cmd_t;

	typedef struct packed {
		logic has_upper;
		logic has_left;
		logic has_corner;
		logic root_done;
		logic out_free;
	} dp_status_t;

endpackage

/* rtl/cdg_if.sv */
// ----------------------------------------------------------------------------
// cdg channel interfaces
// valid/ready channels for the pixel stream and the gradient results
// ----------------------------------------------------------------------------
interface cdg_pixel_if import cdg_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface cdg_result_if import cdg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [GRAD_W-1:0] grad_x;
	logic signed [GRAD_W-1:0] grad_y;
	logic [MAG_W-1:0]         magnitude;
	logic [COL_W-1:0]         col;
	logic [ROW_W-1:0]         row;
	logic                     last;

	modport source (output valid, output grad_x, output grad_y, output magnitude,
		output col, output row, output last, input ready);
	modport sink (input valid, input grad_x, input grad_y, input magnitude,
		input col, input row, input last, output ready);
endinterface

/* rtl/cdg_ram.sv */
// ----------------------------------------------------------------------------
// cdg_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module cdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/cdg_isqrt.sv */
// ----------------------------------------------------------------------------
// cdg_isqrt
// squares both gradients, then finds the floor square root one bit a cycle
// ----------------------------------------------------------------------------
module cdg_isqrt import cdg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [GRAD_W-1:0] gx,
	input  logic signed [GRAD_W-1:0] gy,
	output logic [MAG_W-1:0]         root,
	output logic                     done
);

	logic signed [SQ_W-1:0] gx_sq;
	logic signed [SQ_W-1:0] gy_sq;
	logic [SQ_W-1:0]        sum_sq_q;
	logic [MAG_W-1:0]       root_q;
	logic [STEP_W-1:0]      step_q;
	logic                   run_q;
	logic [MAG_W-1:0]       trial;
	logic [SQ_W-1:0]        trial_sq;

	assign gx_sq    = SQ_W'(gx) * SQ_W'(gx);
	assign gy_sq    = SQ_W'(gy) * SQ_W'(gy);
	assign trial    = root_q | (MAG_W'(1) << step_q);
	assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			step_q <= STEP_W'(MAG_W - 1);
		end else if (run_q) begin
			if (step_q == '0) begin
				run_q <= 1'b0;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			sum_sq_q <= $unsigned(gx_sq) + $unsigned(gy_sq);
			root_q   <= '0;
		end else if (run_q && (trial_sq <= sum_sq_q)) begin
			root_q <= trial;
		end
	end

	assign root = root_q;
	assign done = run_q && (step_q == '0);

endmodule

/* rtl/cdg_datapath.sv */
// ----------------------------------------------------------------------------
// cdg_datapath
// size registers, counters, line stores, gradient select and output register
// ----------------------------------------------------------------------------
module cdg_datapath import cdg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [PIX_W-1:0]     pixel,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           st,
	cdg_result_if.source         results
);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_m1;
	logic [COL_W-1:0] col_p1;
	logic             last_col;
	logic             last_row;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] rec0_q;
	logic [PIX_W-1:0] rec1_q;

	logic [COL_W-1:0] prev_raddr;
	logic [COL_W-1:0] prev_waddr;
	logic [PIX_W-1:0] prev_wdata;
	logic             prev_we;
	logic [PIX_W-1:0] prev_rdata;
	logic             older_we;
	logic [PIX_W-1:0] older_rdata;
	logic [PIX_W-1:0] older_q;
	logic [PIX_W-1:0] prev_m1_q;
	logic [PIX_W-1:0] prev_p1_q;

	logic signed [GRAD_W-1:0] sel_gx;
	logic signed [GRAD_W-1:0] sel_gy;
	logic [COL_W-1:0]         sel_col;
	logic [ROW_W-1:0]         sel_row;
	logic                     sel_last;
	logic [COL_W-1:0]         res_col_q;
	logic [ROW_W-1:0]         res_row_q;
	logic signed [GRAD_W-1:0] res_gx_q;
	logic signed [GRAD_W-1:0] res_gy_q;
	logic                     res_last_q;
	logic [MAG_W-1:0]         root;
	logic                     root_done;

	logic                     out_valid_q;
	logic signed [GRAD_W-1:0] out_gx_q;
	logic signed [GRAD_W-1:0] out_gy_q;
	logic [MAG_W-1:0]         out_mag_q;
	logic [COL_W-1:0]         out_col_q;
	logic [ROW_W-1:0]         out_row_q;
	logic                     out_last_q;

	// floor((a - b) / 2)
	function automatic logic signed [GRAD_W-1:0] half_diff(
		input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b
	);
		logic [PIX_W:0] d;
		d = {1'b0, a} - {1'b0, b};
		return d[PIX_W:1];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize saturates
	assign w_eff = (width_q == '0) ? CFG_W'(1) :
		((width_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_q);
	assign h_eff = (height_q == '0) ? CFG_W'(1) :
		((height_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_q);

	assign col_m1   = col_q - COL_W'(1);
	assign col_p1   = col_q + COL_W'(1);
	assign last_col = (CFG_W'(col_q) + CFG_W'(1)) >= w_eff;
	assign last_row = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rec0_q <= '0;
			rec1_q <= '0;
		end else if (cmd.advance) begin
			rec1_q <= rec0_q;
			rec0_q <= pix_q;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_p1;
			end
		end
	end

	// line store: read c, read c-1, read c+1 and write c-1, write c if last col
	always_comb begin
		prev_raddr = col_q;
		prev_waddr = col_q;
		prev_wdata = pix_q;
		prev_we    = 1'b0;
		older_we   = 1'b0;
		case (cmd.mem_phase)
			MEM_READ_CUR: prev_raddr = col_q;
			MEM_READ_LEFT: begin
				prev_raddr = col_m1;
				older_we   = 1'b1;
			end
			MEM_READ_RIGHT: begin
				prev_raddr = col_p1;
				prev_waddr = col_m1;
				prev_wdata = rec0_q;
				prev_we    = (col_q != '0);
			end
			MEM_WRITE_CUR: prev_we = last_col;
			default: ;
		endcase
	end

	cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev_row (
		.clk   (clk),
		.we    (prev_we),
		.waddr (prev_waddr),
		.wdata (prev_wdata),
		.raddr (prev_raddr),
		.rdata (prev_rdata)
	);

	cdg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_row (
		.clk   (clk),
		.we    (older_we),
		.waddr (col_q),
		.wdata (prev_rdata),
		.raddr (col_q),
		.rdata (older_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel;
		end
		case (cmd.mem_phase)
			MEM_READ_LEFT:  older_q   <= older_rdata;
			MEM_READ_RIGHT: prev_m1_q <= prev_rdata;
			MEM_WRITE_CUR:  prev_p1_q <= prev_rdata;
			default: ;
		endcase
	end

	assign st.has_upper  = (row_q != '0);
	assign st.has_left   = last_row && (col_q != '0);
	assign st.has_corner = last_row && last_col;
	assign st.root_done  = root_done;
	assign st.out_free   = !out_valid_q || results.ready;

	always_comb begin
		sel_gx   = '0;
		sel_gy   = '0;
		sel_col  = col_q;
		sel_row  = row_q;
		sel_last = 1'b1;
		case (cmd.kind)
			KIND_UPPER: begin
				// result of the row above, finished by this pixel
				if ((col_q != '0) && !last_col) begin
					sel_gx = half_diff(prev_p1_q, prev_m1_q);
				end
				if ((row_q != ROW_W'(1)) && (CFG_W'(row_q) < h_eff)) begin
					sel_gy = half_diff(pix_q, older_q);
				end
				sel_row  = row_q - ROW_W'(1);
				sel_last = !(st.has_left || st.has_corner);
			end
			KIND_LEFT: begin
				if ((col_q != COL_W'(1)) && (CFG_W'(col_q) < w_eff)) begin
					sel_gx = half_diff(pix_q, rec1_q);
				end
				sel_col  = col_m1;
				sel_last = !st.has_corner;
			end
			default: ;
		endcase
	end

	cdg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.load_res),
		.gx     (sel_gx),
		.gy     (sel_gy),
		.root   (root),
		.done   (root_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			res_gx_q   <= sel_gx;
			res_gy_q   <= sel_gy;
			res_col_q  <= sel_col;
			res_row_q  <= sel_row;
			res_last_q <= sel_last;
		end
		if (cmd.push_out) begin
			out_gx_q   <= res_gx_q;
			out_gy_q   <= res_gy_q;
			out_mag_q  <= root;
			out_col_q  <= res_col_q;
			out_row_q  <= res_row_q;
			out_last_q <= res_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.grad_x    = out_gx_q;
	assign results.grad_y    = out_gy_q;
	assign results.magnitude = out_mag_q;
	assign results.col       = out_col_q;
	assign results.row       = out_row_q;
	assign results.last      = out_last_q;

endmodule

/* rtl/cdg_ctrl.sv */
// ----------------------------------------------------------------------------
// cdg_ctrl
// sequencer: line store accesses, then each pending result through the root
// ----------------------------------------------------------------------------
module cdg_ctrl import cdg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_CUR,
		ST_RD_LEFT,
		ST_RD_RIGHT,
		ST_WR,
		ST_PICK,
		ST_LOAD,
		ST_ROOT,
		ST_OUT,
		ST_ADV
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= KIND_UPPER;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RD_CUR;
						ready_q <= 1'b0;
					end
				end
				ST_RD_CUR:   state_q <= ST_RD_LEFT;
				ST_RD_LEFT:  state_q <= ST_RD_RIGHT;
				ST_RD_RIGHT: state_q <= ST_WR;
				ST_WR: begin
					state_q <= ST_PICK;
					kind_q  <= KIND_UPPER;
				end
				ST_PICK: begin
					// skip results this pixel does not cause
					unique case (kind_q)
						KIND_UPPER: begin
							if (st.has_upper) begin
								state_q <= ST_LOAD;
							end else begin
								kind_q <= KIND_LEFT;
							end
						end
						KIND_LEFT: begin
							if (st.has_left) begin
								state_q <= ST_LOAD;
							end else begin
								kind_q <= KIND_CORNER;
							end
						end
						default: begin
							state_q <= st.has_corner ? ST_LOAD : ST_ADV;
						end
					endcase
				end
				ST_LOAD: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (st.root_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (st.out_free) begin
						unique case (kind_q)
							KIND_UPPER: begin
								kind_q  <= KIND_LEFT;
								state_q <= ST_PICK;
							end
							KIND_LEFT: begin
								kind_q  <= KIND_CORNER;
								state_q <= ST_PICK;
							end
							default: state_q <= ST_ADV;
						endcase
					end
				end
				ST_ADV: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.kind      = kind_q;
		cmd.mem_phase = MEM_NONE;
		unique case (state_q)
			ST_IDLE:     cmd.capture   = ready_q && in_valid;
			ST_RD_CUR:   cmd.mem_phase = MEM_READ_CUR;
			ST_RD_LEFT:  cmd.mem_phase = MEM_READ_LEFT;
			ST_RD_RIGHT: cmd.mem_phase = MEM_READ_RIGHT;
			ST_WR:       cmd.mem_phase = MEM_WRITE_CUR;
			ST_LOAD:     cmd.load_res  = 1'b1;
			ST_OUT:      cmd.push_out  = st.out_free;
			ST_ADV:      cmd.advance   = 1'b1;
			default: ;
		endcase
	end

	assign in_ready = ready_q;

endmodule

/* rtl/central_difference_gradient_unit.sv */
// ----------------------------------------------------------------------------
// central difference gradient unit
// pixels: 8-bit gray values in raster order, valid/ready, one per request.
// results: grad_x, grad_y (halved central differences), magnitude (floor
//   root of their squares), col and row of the pixel, last on the final
//   result a pixel causes. results lag one row; the final row releases its
//   own results as well, up to three per pixel.
// cfg_write/cfg_index/cfg_data set image_width (index 0) and image_height
//   (index 1); write them only while no pixel is in flight.
// one pixel is in flight at a time. the root is found one bit a cycle, and
//   the previous row store is read three times through its single read port.
// a stalled receiver holds the output register; the unit finishes that
//   pixel's remaining results only as the register frees up.
// reset clears counters and recent pixels, sets 640 x 480; line stores are
//   not cleared and the unit is ready for a pixel as it leaves reset.
// ----------------------------------------------------------------------------
module central_difference_gradient_unit import cdg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	cdg_pixel_if.sink            pixels,
	cdg_result_if.source         results
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	cdg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cdg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixels.pixel),
		.cmd       (cmd),
		.st        (st),
		.results   (results)
	);

endmodule

/* rtl/cdg_checker.sv */
// ----------------------------------------------------------------------------
// cdg_checker
// port level checks of the gradient unit, bound to the top level
// ----------------------------------------------------------------------------
`include "central_difference_gradient_unit_macros.svh"

module cdg_checker import cdg_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [GRAD_W-1:0] grad_x,
	input logic signed [GRAD_W-1:0] grad_y,
	input logic [MAG_W-1:0]         magnitude,
	input logic [COL_W-1:0]         col,
	input logic [ROW_W-1:0]         row,
	input logic                     last
);

	logic signed [SQ_W-1:0] gx_sq;
	logic signed [SQ_W-1:0] gy_sq;
	logic [SQ_W:0]          grad_sq;
	logic [2*MAG_W+1:0]     mag_sq;
	logic [2*MAG_W+1:0]     mag_next_sq;
	logic [MAG_W:0]         mag_p1;

	assign gx_sq       = SQ_W'(grad_x) * SQ_W'(grad_x);
	assign gy_sq       = SQ_W'(grad_y) * SQ_W'(grad_y);
	assign grad_sq     = (SQ_W + 1)'($unsigned(gx_sq)) + (SQ_W + 1)'($unsigned(gy_sq));
	assign mag_p1      = {1'b0, magnitude} + (MAG_W + 1)'(1);
	assign mag_sq      = (2 * MAG_W + 2)'(magnitude) * (2 * MAG_W + 2)'(magnitude);
	assign mag_next_sq = (2 * MAG_W + 2)'(mag_p1) * (2 * MAG_W + 2)'(mag_p1);

	// stalled result holds
	`CDG_ASSERT_NEXT(a_result_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(grad_x) && $stable(grad_y) && $stable(magnitude) &&
		$stable(col) && $stable(row) && $stable(last), "result changed under stall")

	// one pixel in flight: ready drops after a request is taken
	`CDG_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready,
		"second pixel taken while one is in flight")

	// a new result only appears while a pixel is being worked on
	`CDG_ASSERT_NOW(a_result_needs_pixel, clk, arst_n, $rose(out_valid), $past(!in_ready),
		"result appeared with no pixel in flight")

	// magnitude is the floor root of the squared gradients
	`CDG_ASSERT_NOW(a_magnitude_root, clk, arst_n, out_valid,
		((SQ_W + 2)'(mag_sq) <= (SQ_W + 2)'(grad_sq)) &&
		((SQ_W + 2)'(grad_sq) < (SQ_W + 2)'(mag_next_sq)), "magnitude is not the floor root")

endmodule

bind central_difference_gradient_unit cdg_checker u_cdg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.grad_x    (results.grad_x),
	.grad_y    (results.grad_y),
	.magnitude (results.magnitude),
	.col       (results.col),
	.row       (results.row),
	.last      (results.last)
);
